[src/tct_pkg.sv]
// shared types and constants for the taylor cosine tolerance block
package tct_pkg;

	localparam int unsigned MAX_TERMS_DEF = 16;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned TOL_W = 30;
	localparam int unsigned COS_W = 32;
	localparam int unsigned DEG_W = 7;
	localparam int unsigned THETA_W = 31;
	localparam int unsigned THETA2_W = 32;
	localparam int unsigned MAG_W = 31;
	localparam int unsigned SUM_W = 33;
	localparam int unsigned OFF_W = 41;
	localparam int unsigned RECIP_W = 33;
	localparam int unsigned SHIFT_W = 6;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [15:0] ANGLE_MAX = 16'd32768;
	localparam logic [TOL_W-1:0] TOL_RESET = 30'd1074;
	localparam logic [MAG_W-1:0] ONE_MAG = 31'd1073741824;
	localparam logic signed [SUM_W-1:0] ONE_SUM = 33'sd1073741824;

	// running state of one series as it moves down the chain
	typedef struct packed {
		logic valid;
		logic active;
		logic lim;
		logic [DEG_W-1:0] deg;
		logic [MAG_W-1:0] mag;
		logic signed [SUM_W-1:0] sum;
	} term_t;

	// per-term constants: rounding offset, reciprocal of (2k-1)(2k) and its shift, degree, sign, last flag
	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [RECIP_W-1:0] recip;
		logic [SHIFT_W-1:0] shift;
		logic [DEG_W-1:0] deg;
		logic neg;
		logic last;
	} cell_const_t;

endpackage

[src/tct_cell.sv]
// one series term: multiply by theta^2, divide by (2k-1)(2k), accumulate
module tct_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [tct_pkg::THETA2_W-1:0] theta2,
	input logic [tct_pkg::TOL_W-1:0] tolerance,
	input tct_pkg::cell_const_t cst,
	input tct_pkg::term_t link_in,
	output tct_pkg::term_t link_out
);
	import tct_pkg::*;

	logic v_s1, v_s2, v_s3;
	term_t carry_s1, carry_s2, term_s3;
	logic [31:0] n_s1;
	logic [64:0] prod_s2;
	logic [63:0] prod_a;
	logic [MAG_W-1:0] q;
	term_t res;

	// mag * theta2 plus half the divisor, then drop the Q30 scale
	assign prod_a = 64'(link_in.mag) * 64'(theta2) + 64'(cst.off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= link_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1 <= link_in;
			n_s1 <= prod_a[61:30];
			carry_s2 <= carry_s1;
			prod_s2 <= 65'(n_s1) * 65'(cst.recip);
			term_s3 <= res;
		end
	end

	// exact floor division by the term's divisor via rounded-up reciprocal
	assign q = MAG_W'(prod_s2 >> cst.shift);

	always_comb begin
		res = carry_s2;
		if (carry_s2.active) begin
			res.mag = q;
			res.deg = cst.deg;
			if (cst.neg) begin
				res.sum = carry_s2.sum - $signed({2'b00, q});
			end else begin
				res.sum = carry_s2.sum + $signed({2'b00, q});
			end
			if ({1'b0, q} < {2'b00, tolerance}) begin
				res.active = 1'b0;
			end else if (cst.last) begin
				res.lim = 1'b1;
			end
		end
	end

	always_comb begin
		link_out = term_s3;
		link_out.valid = v_s3;
	end

endmodule

[src/taylor_cosine_tolerance.sv]
// path: input request through the theta and theta^2 registers, then the term cells, then the output register
// one item is in the chain at a time; the next request is taken once the result leaves the chain
// each term cell registers its steps in order: theta^2 multiply, reciprocal multiply, accumulate
// a waiting result does not block the next input request; the chain stalls at its tail
// reset clears all valid bits and sets tolerance to 1074; no clearing pass
module taylor_cosine_tolerance #(
	parameter int unsigned MAX_TERMS = tct_pkg::MAX_TERMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [tct_pkg::ANGLE_W-1:0] angle_turns,
	output logic out_valid,
	input logic out_ready,
	output logic signed [tct_pkg::COS_W-1:0] cosine,
	output logic [tct_pkg::DEG_W-1:0] degree,
	output logic limit_hit,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tct_pkg::TOL_W-1:0] tolerance
);
	import tct_pkg::*;

	logic [TOL_W-1:0] tolerance_q;
	logic busy_q;
	logic pv_s1, pv_s2;
	logic [THETA_W-1:0] theta_s1;
	logic [THETA2_W-1:0] theta2_s2;
	logic out_valid_q;
	logic signed [COS_W-1:0] cosine_q;
	logic [DEG_W-1:0] degree_q;
	logic limit_q;

	logic in_fire, en, tail_fire;
	logic [ANGLE_W-1:0] ang_sat;
	logic [47:0] theta_full;
	logic [61:0] theta2_full;
	logic signed [COS_W-1:0] cos_sat;
	term_t link [0:MAX_TERMS];

	assign in_ready = !busy_q;
	assign in_fire = in_valid && in_ready;
	// tolerance only changes while no request is in the chain
	assign cfg_ready = !busy_q;

	assign ang_sat = (angle_turns > ANGLE_MAX) ? ANGLE_MAX : angle_turns;
	assign theta_full = 48'(ang_sat) * 48'(PI_Q30) + 48'd32768;
	assign theta2_full = 62'(theta_s1) * 62'(theta_s1) + 62'(32'h2000_0000);

	// chain holds only while its result cannot move to the output register
	assign en = !(link[MAX_TERMS].valid && out_valid_q && !out_ready);
	assign tail_fire = link[MAX_TERMS].valid && en;

	always_comb begin
		link[0].valid = pv_s2;
		link[0].active = 1'b1;
		link[0].lim = 1'b0;
		link[0].deg = '0;
		link[0].mag = ONE_MAG;
		link[0].sum = ONE_SUM;
	end

	for (genvar k = 1; k <= MAX_TERMS; k++) begin : g_cell
		localparam longint unsigned C = longint'((2 * k - 1) * (2 * k));
		localparam int L = $clog2(C);
		localparam longint unsigned M = ((64'd1 << (32 + L)) + C - 1) / C;
		cell_const_t cst;

		assign cst.off = OFF_W'(C << 29);
		assign cst.recip = RECIP_W'(M);
		assign cst.shift = SHIFT_W'(32 + L);
		assign cst.deg = DEG_W'(2 * k);
		assign cst.neg = 1'((k % 2) == 1);
		assign cst.last = 1'(k == MAX_TERMS);

		tct_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.theta2(theta2_s2),
			.tolerance(tolerance_q),
			.cst(cst),
			.link_in(link[k-1]),
			.link_out(link[k])
		);
	end

	always_comb begin
		if (link[MAX_TERMS].sum[SUM_W-1] != link[MAX_TERMS].sum[SUM_W-2]) begin
			cos_sat = link[MAX_TERMS].sum[SUM_W-1] ? {1'b1, {(COS_W-1){1'b0}}}
				: {1'b0, {(COS_W-1){1'b1}}};
		end else begin
			cos_sat = link[MAX_TERMS].sum[COS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
			busy_q <= 1'b0;
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tolerance_q <= tolerance;
			end
			pv_s1 <= in_fire;
			pv_s2 <= pv_s1;
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (tail_fire) begin
				busy_q <= 1'b0;
			end
			if (tail_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			theta_s1 <= theta_full[46:16];
		end
		if (pv_s1) begin
			theta2_s2 <= theta2_full[61:30];
		end
		if (tail_fire) begin
			cosine_q <= cos_sat;
			degree_q <= link[MAX_TERMS].deg;
			limit_q <= link[MAX_TERMS].lim;
		end
	end

	assign out_valid = out_valid_q;
	assign cosine = cosine_q;
	assign degree = degree_q;
	assign limit_hit = limit_q;

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (degree[0] == 1'b0) && (degree >= DEG_W'(2))
			&& (degree <= DEG_W'(2 * MAX_TERMS)))
		else $error("degree out of range");

	a_limit_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit |-> degree == DEG_W'(2 * MAX_TERMS))
		else $error("limit flag without a full series");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		link[MAX_TERMS].valid |-> busy_q)
		else $error("chain result with no request in flight");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> !pv_s2 && !link[MAX_TERMS].valid)
		else $error("two requests in flight");

endmodule
